/* sv/bpa_pkg.sv */
// Shared types and codes for the buffer pool slot manager.
// Used by the scan cells, the controller, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

	localparam logic [1:0] KIND_ALLOC    = 2'd0;
	localparam logic [1:0] KIND_LOOKUP   = 2'd1;
	localparam logic [1:0] KIND_SETDIRTY = 2'd2;
	localparam logic [1:0] KIND_NONE     = 2'd3;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_OOB  = 2'd1;
	localparam logic [1:0] STATUS_MISS = 2'd2;

	localparam logic [15:0] AGE_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef enum logic {
		OP_INSTALL,
		OP_MARK
	} cmt_op_t;

	// Request held steady while the scan token runs down the cells.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] blk;
	} sreq_t;

	// Running result carried by the scan token from cell to cell.
	typedef struct packed {
		logic        valid;
		logic        free_found;
		logic        best_valid;
		logic [15:0] best_age;
		logic        best_dirty;
		logic [15:0] best_blk;
		logic        match_found;
	} tok_t;

	// Broadcast from the controller at the end of a scan.
	typedef struct packed {
		logic        en;
		cmt_op_t     op;
		logic [15:0] blk;
	} cmt_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  slot;
		logic        wb_valid;
		logic [15:0] wb_block;
	} rsp_t;

endpackage

`default_nettype wire

/* sv/bpa_req_if.sv */
// Request channel: valid/ready handshake with kind and block number.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] block_num;

	modport source (output valid, output kind, output block_num, input ready);
	modport sink   (input valid, input kind, input block_num, output ready);
endinterface

`default_nettype wire

/* sv/bpa_rsp_if.sv */
// Response channel: valid/ready handshake with status, slot and writeback.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface bpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [4:0]  slot;
	logic        writeback_valid;
	logic [15:0] writeback_block;

	modport source (output valid, output status, output slot, output writeback_valid,
		output writeback_block, input ready);
	modport sink   (input valid, input status, input slot, input writeback_valid,
		input writeback_block, output ready);
endinterface

`default_nettype wire

/* sv/bpa_cell.sv */
// One buffer slot: occupied, dirty, age and held block, plus one stage of the
// scan token chain. Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpa_cell #(
	parameter int IW  = 5,
	parameter int IDX = 0
) (
	input  wire             clk,
	input  wire             arst_n,
	input  bpa_pkg::sreq_t  sreq,
	input  bpa_pkg::cmt_t   cmt,
	input  wire [IW-1:0]    cmt_idx,
	input  bpa_pkg::tok_t   tok_i,
	input  wire [IW-1:0]    free_idx_i,
	input  wire [IW-1:0]    best_idx_i,
	input  wire [IW-1:0]    match_idx_i,
	output bpa_pkg::tok_t   tok_o,
	output logic [IW-1:0]   free_idx_o,
	output logic [IW-1:0]   best_idx_o,
	output logic [IW-1:0]   match_idx_o
);
	import bpa_pkg::*;

	logic        occ_q;
	logic        dirty_q;
	logic [15:0] age_q;
	logic [15:0] blk_q;

	logic [15:0]   aged;
	logic          is_alloc;
	logic          hit;
	tok_t          t;
	logic [IW-1:0] fi, bi, mi;
	tok_t          tok_q;
	logic [IW-1:0] free_idx_q, best_idx_q, match_idx_q;

	assign aged     = (occ_q && age_q != AGE_MAX) ? age_q + 16'd1 : age_q;
	assign is_alloc = (sreq.kind == KIND_ALLOC);
	assign hit      = cmt.en && (cmt_idx == IW'(IDX));

	always_comb begin
		t  = tok_i;
		fi = free_idx_i;
		bi = best_idx_i;
		mi = match_idx_i;
		if (tok_i.valid) begin
			if (is_alloc) begin
				if (!occ_q && !tok_i.free_found) begin
					t.free_found = 1'b1;
					fi = IW'(IDX);
				end
				// Strictly greater keeps the lowest slot on a tie.
				if (occ_q && (!tok_i.best_valid || aged > tok_i.best_age)) begin
					t.best_valid = 1'b1;
					t.best_age   = aged;
					t.best_dirty = dirty_q;
					t.best_blk   = blk_q;
					bi = IW'(IDX);
				end
			end else if (occ_q && blk_q == sreq.blk && !tok_i.match_found) begin
				t.match_found = 1'b1;
				mi = IW'(IDX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= t;
		end
	end

	always_ff @(posedge clk) begin
		free_idx_q  <= fi;
		best_idx_q  <= bi;
		match_idx_q <= mi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			dirty_q <= 1'b0;
			age_q   <= 16'd0;
		end else begin
			if (tok_i.valid && is_alloc) begin
				age_q <= aged;
			end
			if (hit) begin
				case (cmt.op)
					OP_INSTALL: begin
						occ_q   <= 1'b1;
						dirty_q <= 1'b0;
						age_q   <= 16'd0;
					end
					OP_MARK: dirty_q <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && cmt.op == OP_INSTALL) begin
			blk_q <= cmt.blk;
		end
	end

	assign tok_o       = tok_q;
	assign free_idx_o  = free_idx_q;
	assign best_idx_o  = best_idx_q;
	assign match_idx_o = match_idx_q;

endmodule

`default_nettype wire

/* sv/bpa_ctrl.sv */
// Request sequencer: accepts items, launches the scan token, turns the token
// that leaves the last cell into a slot update and a response. Depends on
// bpa_pkg, bpa_req_if and bpa_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl #(
	parameter int IW          = 5,
	parameter int BLOCK_COUNT = 8192
) (
	input  wire             clk,
	input  wire             arst_n,
	bpa_req_if.sink         req,
	bpa_rsp_if.source       rsp,
	output bpa_pkg::sreq_t  sreq,
	output logic            launch,
	output bpa_pkg::cmt_t   cmt,
	output logic [IW-1:0]   cmt_idx,
	input  bpa_pkg::tok_t   tok_end,
	input  wire [IW-1:0]    free_idx_end,
	input  wire [IW-1:0]    best_idx_end,
	input  wire [IW-1:0]    match_idx_end
);
	import bpa_pkg::*;

	state_t state_q, state_d;
	sreq_t  sreq_q;
	logic   launch_q;
	rsp_t   res_q, res_d, out_q;
	logic   out_valid_q;

	logic accept, immediate, oob, out_free, load_out, load_res;
	rsp_t imm_rsp, scan_rsp;
	logic [IW-1:0] victim;

	assign oob = ({1'b0, req.block_num} >= 17'(BLOCK_COUNT)) && (req.kind != KIND_NONE);
	assign immediate = oob || (req.kind == KIND_NONE);
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		imm_rsp        = '0;
		imm_rsp.status = oob ? STATUS_OOB : STATUS_OK;
	end

	// Result and slot update once the token has visited every cell.
	always_comb begin
		scan_rsp = '0;
		cmt      = '0;
		cmt_idx  = '0;
		victim   = tok_end.free_found ? free_idx_end : best_idx_end;
		if (sreq_q.kind == KIND_ALLOC) begin
			scan_rsp.slot = 5'(victim);
			if (!tok_end.free_found && tok_end.best_dirty) begin
				scan_rsp.wb_valid = 1'b1;
				scan_rsp.wb_block = tok_end.best_blk;
			end
			cmt.en  = tok_end.valid;
			cmt.op  = OP_INSTALL;
			cmt.blk = sreq_q.blk;
			cmt_idx = victim;
		end else if (tok_end.match_found) begin
			scan_rsp.slot = 5'(match_idx_end);
			cmt.en  = tok_end.valid && (sreq_q.kind == KIND_SETDIRTY);
			cmt.op  = OP_MARK;
			cmt_idx = match_idx_end;
		end else begin
			scan_rsp.status = STATUS_MISS;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (req.valid) state_d = immediate ? ST_FINISH : ST_SCAN;
			ST_SCAN:   if (tok_end.valid) state_d = out_free ? ST_IDLE : ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		load_out  = 1'b0;
		load_res  = 1'b0;
		res_d     = res_q;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				load_res  = req.valid;
				res_d     = imm_rsp;
			end
			ST_SCAN: begin
				load_res = tok_end.valid;
				load_out = tok_end.valid && out_free;
				res_d    = scan_rsp;
			end
			ST_FINISH: begin
				load_out = out_free;
			end
			default: ;
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept && !immediate;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sreq_q <= '{kind: req.kind, blk: req.block_num};
		end
		if (load_res) begin
			res_q <= res_d;
		end
		if (load_out) begin
			out_q <= (state_q == ST_SCAN) ? scan_rsp : res_q;
		end
	end

	assign sreq   = sreq_q;
	assign launch = launch_q;

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_q.status;
	assign rsp.slot            = out_q.slot;
	assign rsp.writeback_valid = out_q.wb_valid;
	assign rsp.writeback_block = out_q.wb_block;

endmodule

`default_nettype wire

/* sv/buffer_pool_age_replacement.sv */
// Buffer pool slot manager with oldest-victim replacement: top level with the
// controller and a row of SLOTS slot cells. Depends on bpa_pkg and interfaces.
//
//   Channel  Dir  Payload                                           Handshake
//   req      in   kind[1:0], block_num[15:0]                         valid/ready
//   rsp      out  status[1:0], slot[4:0], writeback_valid,
//                 writeback_block[15:0]                              valid/ready
//
// A scan token steps one cell per cycle, so an allocate, lookup or set-dirty
// item is done with the whole row of cells before the next item is accepted.
// Out-of-bound and unused-kind items answer without a scan.
// Reset clears every slot to free, clean and age zero at once.
// One item is in work at a time; a stalled response holds in the output
// register while the next item is taken and scanned.
`timescale 1ns / 1ps
`default_nettype none

module buffer_pool_age_replacement #(
	parameter int SLOTS       = 32,
	parameter int BLOCK_COUNT = 8192
) (
	input  wire       clk,
	input  wire       arst_n,
	bpa_req_if.sink   req,
	bpa_rsp_if.source rsp
);
	import bpa_pkg::*;

	localparam int IW = $clog2(SLOTS);

	sreq_t         sreq;
	logic          launch;
	cmt_t          cmt;
	logic [IW-1:0] cmt_idx;

	tok_t          tok       [SLOTS+1];
	logic [IW-1:0] free_idx  [SLOTS+1];
	logic [IW-1:0] best_idx  [SLOTS+1];
	logic [IW-1:0] match_idx [SLOTS+1];

	always_comb begin
		tok[0]       = '0;
		tok[0].valid = launch;
	end
	assign free_idx[0]  = '0;
	assign best_idx[0]  = '0;
	assign match_idx[0] = '0;

	bpa_ctrl #(
		.IW          (IW),
		.BLOCK_COUNT (BLOCK_COUNT)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.sreq          (sreq),
		.launch        (launch),
		.cmt           (cmt),
		.cmt_idx       (cmt_idx),
		.tok_end       (tok[SLOTS]),
		.free_idx_end  (free_idx[SLOTS]),
		.best_idx_end  (best_idx[SLOTS]),
		.match_idx_end (match_idx[SLOTS])
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		bpa_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.sreq        (sreq),
			.cmt         (cmt),
			.cmt_idx     (cmt_idx),
			.tok_i       (tok[i]),
			.free_idx_i  (free_idx[i]),
			.best_idx_i  (best_idx[i]),
			.match_idx_i (match_idx[i]),
			.tok_o       (tok[i+1]),
			.free_idx_o  (free_idx[i+1]),
			.best_idx_o  (best_idx[i+1]),
			.match_idx_o (match_idx[i+1])
		);
	end

endmodule

`default_nettype wire

/* sv/bpa_checker.sv */
// Port-level checks for the buffer pool slot manager, bound to its top level.
// Depends on bpa_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module bpa_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        req_valid,
	input wire        req_ready,
	input wire        rsp_valid,
	input wire        rsp_ready,
	input wire [1:0]  rsp_status,
	input wire [4:0]  rsp_slot,
	input wire        rsp_wb_valid,
	input wire [15:0] rsp_wb_block
);
	import bpa_pkg::*;

	// One item at a time: an accepted item closes the request side.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in work");

	a_fail_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STATUS_OK |-> rsp_slot == 5'd0 && !rsp_wb_valid)
		else $error("failed response carries a slot or writeback");

	a_wb_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_wb_valid |-> rsp_wb_block == 16'd0)
		else $error("writeback block set without writeback");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
			&& $stable(rsp_wb_valid) && $stable(rsp_wb_block))
		else $error("stalled response changed");

endmodule

bind buffer_pool_age_replacement bpa_checker u_bpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_slot     (rsp.slot),
	.rsp_wb_valid (rsp.writeback_valid),
	.rsp_wb_block (rsp.writeback_block)
);

`default_nettype wire
